FILE: sv/vtpg_pkg.sv
`default_nettype none

package vtpg_pkg;

	localparam int unsigned PIX_W     = 12;
	localparam int unsigned DIM_W     = 13;
	localparam int unsigned CH_W      = 8;
	localparam int unsigned NUM_CH    = 4;
	localparam int unsigned PROD_W    = 20;
	localparam int unsigned GR_W      = 21;
	localparam int unsigned RP_W      = 20;
	localparam int unsigned ADDR_W    = 5;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned DIV_STEPS = PIX_W;
	localparam int unsigned NUM_BARS  = 7;
	localparam int unsigned BAR_W     = 3;
	localparam int unsigned GRID_LOG2 = 5;

	localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

	localparam logic [CH_W-1:0] GREY_HI      = 8'd220;
	localparam logic [CH_W-1:0] GREY_LO      = 8'd40;
	localparam logic [CH_W-1:0] GRID_GREY    = 8'd80;
	localparam logic [CH_W-1:0] BAR_LEVEL    = 8'd192;
	localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;

	typedef enum logic [1:0] {
		MODE_SOLID    = 2'd0,
		MODE_GRADIENT = 2'd1,
		MODE_CHECKER  = 2'd2,
		MODE_TEST     = 2'd3
	} vtpg_mode_t;

	typedef enum logic [2:0] {
		REG_MODE         = 3'd0,
		REG_FRAME_WIDTH  = 3'd1,
		REG_FRAME_HEIGHT = 3'd2,
		REG_COLOR_ONE    = 3'd3,
		REG_COLOR_TWO    = 3'd4,
		REG_CHECKER_SIZE = 3'd5
	} vtpg_reg_t;

	// divisors shared by every step of the divide array
	typedef struct packed {
		logic [DIM_W-1:0] sz;
		logic [PIX_W-1:0] den;
		logic [DIM_W-1:0] den2;
	} vtpg_div_cfg_t;

	// one word in flight through the divide array
	typedef struct packed {
		logic [NUM_CH-1:0][GR_W-1:0] grem;
		logic [NUM_CH-1:0][CH_W-1:0] gq;
		logic [RP_W-1:0]             rrem;
		logic [CH_W-1:0]             rq;
		logic [PIX_W-1:0]            xrem;
		logic [PIX_W-1:0]            yrem;
		logic                        xq;
		logic                        yq;
		logic                        outside;
		logic [BAR_W-1:0]            bar;
		logic                        bar_row;
		logic                        grid;
	} vtpg_stage_t;

endpackage

`default_nettype wire

FILE: sv/vtpg_ifs.sv
`default_nettype none

interface vtpg_coord_if;
	logic                        valid;
	logic                        ready;
	logic [vtpg_pkg::PIX_W-1:0]  pixel_x;
	logic [vtpg_pkg::PIX_W-1:0]  pixel_y;

	modport source (output valid, pixel_x, pixel_y, input ready);
	modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface vtpg_pixel_if;
	logic                       valid;
	logic                       ready;
	logic [vtpg_pkg::CH_W-1:0]  red;
	logic [vtpg_pkg::CH_W-1:0]  green;
	logic [vtpg_pkg::CH_W-1:0]  blue;
	logic [vtpg_pkg::CH_W-1:0]  alpha;
	logic                       outside_frame;

	modport source (output valid, red, green, blue, alpha, outside_frame, input ready);
	modport sink   (input valid, red, green, blue, alpha, outside_frame, output ready);
endinterface

`default_nettype wire

FILE: sv/vtpg_div_stage.sv
`default_nettype none

// One restoring-divide step for every lane, with its own register and valid bit.
module vtpg_div_stage #(
	parameter int unsigned STEP = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  vtpg_pkg::vtpg_div_cfg_t cfg,
	input  logic                    up_valid,
	input  vtpg_pkg::vtpg_stage_t   up_data,
	input  logic                    down_adv,
	output logic                    adv,
	output logic                    valid,
	output vtpg_pkg::vtpg_stage_t   data
);

	localparam int unsigned SH_W = vtpg_pkg::PIX_W + vtpg_pkg::DIM_W;

	logic                  valid_q;
	vtpg_pkg::vtpg_stage_t data_q;
	vtpg_pkg::vtpg_stage_t nxt;
	logic [SH_W-1:0]       sz_sh;
	logic [SH_W-1:0]       den_sh;
	logic [SH_W-1:0]       den2_sh;

	assign adv   = !valid_q || down_adv;
	assign valid = valid_q;
	assign data  = data_q;

	always_comb begin
		sz_sh   = SH_W'(cfg.sz) << STEP;
		den_sh  = SH_W'(cfg.den) << STEP;
		den2_sh = SH_W'(cfg.den2) << STEP;
		nxt     = up_data;

		// checker lanes: only the last quotient bit survives
		nxt.xq = vtpg_pkg::DIM_W'(up_data.xrem >> STEP) >= cfg.sz;
		if (nxt.xq) begin
			nxt.xrem = up_data.xrem - vtpg_pkg::PIX_W'(sz_sh);
		end
		nxt.yq = vtpg_pkg::DIM_W'(up_data.yrem >> STEP) >= cfg.sz;
		if (nxt.yq) begin
			nxt.yrem = up_data.yrem - vtpg_pkg::PIX_W'(sz_sh);
		end

		// gradient and ramp quotients have eight bits
		if (STEP < vtpg_pkg::CH_W) begin
			for (int c = 0; c < vtpg_pkg::NUM_CH; c++) begin
				if ((up_data.grem[c] >> STEP) >= vtpg_pkg::GR_W'(cfg.den2)) begin
					nxt.grem[c] = up_data.grem[c] - vtpg_pkg::GR_W'(den2_sh);
					nxt.gq[c]   = up_data.gq[c] | (vtpg_pkg::CH_W'(1) << STEP);
				end
			end
			if ((up_data.rrem >> STEP) >= vtpg_pkg::RP_W'(cfg.den)) begin
				nxt.rrem = up_data.rrem - vtpg_pkg::RP_W'(den_sh);
				nxt.rq   = up_data.rq | (vtpg_pkg::CH_W'(1) << STEP);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && up_valid) begin
			data_q <= nxt;
		end
	end

endmodule

`default_nettype wire

FILE: sv/video_test_pattern_generator.sv
`default_nettype none

// Video test pattern generator. Each coordinate word on coord returns one RGBA
// word on pixel for the pattern selected by pattern_mode: solid color_one, a
// horizontal gradient from color_one to color_two rounded to nearest, a
// 220/40 grey checkerboard of checker_size squares, or seven colour bars over
// the top two thirds with a grey ramp below and a grey-80 grid every 32 pixels.
// A coordinate beyond the frame returns zero colour with outside_frame set.
// Throughput is one pixel per clock, back to back, while pixel.ready is held high;
// each coord word reaches the pixel port through 16 registers:
// input register, multiply stage, numerator stage, a 12-step restoring divide
// array (one quotient bit per stage, sized by the 12-bit column quotient of the
// checker pattern) and the output register. Stalls ripple back combinationally
// through the stage enables, so bubbles collapse and coord keeps accepting
// while an output word waits until every stage holds a word. Registers sit on
// an APB port at byte address 4*index, pready is tied high, and they may be
// written only while no word is in flight; frame sizes above 4096 are taken as
// 4096 and a checker size of zero as one.
module video_test_pattern_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	vtpg_coord_if.sink                    coord,
	vtpg_pixel_if.source                  pixel,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vtpg_pkg::ADDR_W-1:0]   paddr,
	input  logic [vtpg_pkg::DATA_W-1:0]   pwdata,
	output logic [vtpg_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int unsigned PIX_W  = vtpg_pkg::PIX_W;
	localparam int unsigned DIM_W  = vtpg_pkg::DIM_W;
	localparam int unsigned CH_W   = vtpg_pkg::CH_W;
	localparam int unsigned NCH    = vtpg_pkg::NUM_CH;
	localparam int unsigned NDIV   = vtpg_pkg::DIV_STEPS;
	localparam int unsigned BAR_W  = vtpg_pkg::BAR_W;
	localparam int unsigned LIM_W  = DIM_W + 2;

	// per bar: red, green, blue enables at level 192
	// grey, yellow, cyan, green, magenta, red, blue; code seven never occurs
	localparam logic [(1<<BAR_W)-1:0][2:0] BAR_MASK = {
		3'b000, 3'b001, 3'b100, 3'b101, 3'b010, 3'b011, 3'b110, 3'b111
	};

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	vtpg_pkg::vtpg_mode_t mode_q;
	logic [DIM_W-1:0]     frame_width_q;
	logic [DIM_W-1:0]     frame_height_q;
	logic [31:0]          color_one_q;
	logic [31:0]          color_two_q;
	logic [DIM_W-1:0]     checker_size_q;
	logic                 wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= vtpg_pkg::MODE_SOLID;
			frame_width_q  <= 13'd320;
			frame_height_q <= 13'd240;
			color_one_q    <= 32'hFF00_0000;
			color_two_q    <= 32'hFFFF_FFFF;
			checker_size_q <= 13'd32;
		end else if (wr_en) begin
			// addresses past the last register are dropped
			unique case (paddr[vtpg_pkg::ADDR_W-1:2])
				vtpg_pkg::REG_MODE:         mode_q <= vtpg_pkg::vtpg_mode_t'(pwdata[1:0]);
				vtpg_pkg::REG_FRAME_WIDTH:  frame_width_q <= pwdata[DIM_W-1:0];
				vtpg_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[DIM_W-1:0];
				vtpg_pkg::REG_COLOR_ONE:    color_one_q <= pwdata[31:0];
				vtpg_pkg::REG_COLOR_TWO:    color_two_q <= pwdata[31:0];
				vtpg_pkg::REG_CHECKER_SIZE: checker_size_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[vtpg_pkg::ADDR_W-1:2])
			vtpg_pkg::REG_MODE:         prdata = vtpg_pkg::DATA_W'(mode_q);
			vtpg_pkg::REG_FRAME_WIDTH:  prdata = vtpg_pkg::DATA_W'(frame_width_q);
			vtpg_pkg::REG_FRAME_HEIGHT: prdata = vtpg_pkg::DATA_W'(frame_height_q);
			vtpg_pkg::REG_COLOR_ONE:    prdata = color_one_q;
			vtpg_pkg::REG_COLOR_TWO:    prdata = color_two_q;
			vtpg_pkg::REG_CHECKER_SIZE: prdata = vtpg_pkg::DATA_W'(checker_size_q);
			default:                    prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Values derived from the registers; static while words are in flight
	// ---------------------------------------------------------------------
	logic [DIM_W-1:0]             w_c;
	logic [DIM_W-1:0]             h_c;
	logic [PIX_W-1:0]             d_c;
	logic                         d_zero;
	vtpg_pkg::vtpg_div_cfg_t      div_cfg;
	logic [vtpg_pkg::NUM_BARS-1:1][LIM_W-1:0] bar_lim;

	always_comb begin
		w_c    = (frame_width_q > vtpg_pkg::MAX_DIM) ? vtpg_pkg::MAX_DIM : frame_width_q;
		h_c    = (frame_height_q > vtpg_pkg::MAX_DIM) ? vtpg_pkg::MAX_DIM : frame_height_q;
		d_c    = PIX_W'(w_c - 13'd1);
		d_zero = (w_c == 13'd1);

		div_cfg.den2 = {d_c, 1'b0};
		div_cfg.den  = (w_c > 13'd1) ? d_c : PIX_W'(1);
		div_cfg.sz   = (checker_size_q == '0) ? DIM_W'(1) : checker_size_q;

		// bar k starts where 7x reaches k*w
		for (int k = 1; k < vtpg_pkg::NUM_BARS; k++) begin
			bar_lim[k] = LIM_W'(w_c) * LIM_W'(k);
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1: input register
	// ---------------------------------------------------------------------
	logic             v_s1, adv_s1;
	logic [PIX_W-1:0] x_s1, y_s1;

	assign coord.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= coord.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && coord.valid) begin
			x_s1 <= coord.pixel_x;
			y_s1 <= coord.pixel_y;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: frame test, bar decode, gradient products
	// ---------------------------------------------------------------------
	logic                                 v_s2, adv_s2;
	logic [PIX_W-1:0]                     x_s2, y_s2;
	logic                                 outside_s2, bar_row_s2, grid_s2;
	logic [BAR_W-1:0]                     bar_s2;
	logic [NCH-1:0][vtpg_pkg::PROD_W-1:0] pa_s2, pb_s2;

	logic [LIM_W-1:0]                     x7;
	logic [LIM_W-1:0]                     yp1;
	logic [BAR_W-1:0]                     bar_n;
	logic [NCH-1:0][vtpg_pkg::PROD_W-1:0] pa_n, pb_n;
	logic [PIX_W-1:0]                     dx;

	always_comb begin
		x7    = (LIM_W'(x_s1) << 3) - LIM_W'(x_s1);
		yp1   = LIM_W'(y_s1) + LIM_W'(1);
		bar_n = '0;
		for (int k = 1; k < vtpg_pkg::NUM_BARS; k++) begin
			if (x7 >= bar_lim[k]) begin
				bar_n = bar_n + BAR_W'(1);
			end
		end
		// weights of color one and two: d - x and x
		dx = d_c - x_s1;
		for (int c = 0; c < NCH; c++) begin
			pa_n[c] = vtpg_pkg::PROD_W'(color_one_q[8*c +: 8]) * vtpg_pkg::PROD_W'(dx);
			pb_n[c] = vtpg_pkg::PROD_W'(color_two_q[8*c +: 8]) * vtpg_pkg::PROD_W'(x_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			x_s2       <= x_s1;
			y_s2       <= y_s1;
			outside_s2 <= (DIM_W'(x_s1) >= w_c) || (DIM_W'(y_s1) >= h_c);
			// y below two thirds of h: 3(y+1) <= 2h
			bar_row_s2 <= ((yp1 << 1) + yp1) <= (LIM_W'(h_c) << 1);
			grid_s2    <= (x_s1[vtpg_pkg::GRID_LOG2-1:0] == '0) ||
			              (y_s1[vtpg_pkg::GRID_LOG2-1:0] == '0);
			bar_s2     <= bar_n;
			pa_s2      <= pa_n;
			pb_s2      <= pb_n;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: dividends for the divide array
	// ---------------------------------------------------------------------
	logic                  v_s3, adv_s3;
	vtpg_pkg::vtpg_stage_t st_s3;
	vtpg_pkg::vtpg_stage_t st_n;

	always_comb begin
		st_n = '0;
		// gradient: 2*(a*(d-x) + b*x) + d over 2d, rounds to nearest
		for (int c = 0; c < NCH; c++) begin
			st_n.grem[c] = ((vtpg_pkg::GR_W'(pa_s2[c]) + vtpg_pkg::GR_W'(pb_s2[c])) << 1)
			               + vtpg_pkg::GR_W'(d_c);
		end
		st_n.rrem    = (vtpg_pkg::RP_W'(x_s2) << 8) - vtpg_pkg::RP_W'(x_s2);
		st_n.xrem    = x_s2;
		st_n.yrem    = y_s2;
		st_n.outside = outside_s2;
		st_n.bar     = bar_s2;
		st_n.bar_row = bar_row_s2;
		st_n.grid    = grid_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			st_s3 <= st_n;
		end
	end

	// ---------------------------------------------------------------------
	// Stages 4..15: divide array, most significant quotient bit first
	// ---------------------------------------------------------------------
	logic [NDIV-1:0]       div_valid, div_adv, up_v, down_adv;
	vtpg_pkg::vtpg_stage_t div_data [NDIV];
	vtpg_pkg::vtpg_stage_t up_d     [NDIV];
	logic                  v_s16, adv_s16;

	for (genvar i = 0; i < NDIV; i++) begin : g_div
		if (i == 0) begin : g_first
			assign up_v[i] = v_s3;
			assign up_d[i] = st_s3;
		end else begin : g_next
			assign up_v[i] = div_valid[i-1];
			assign up_d[i] = div_data[i-1];
		end
		if (i == NDIV - 1) begin : g_last
			assign down_adv[i] = adv_s16;
		end else begin : g_mid
			assign down_adv[i] = div_adv[i+1];
		end

		vtpg_div_stage #(
			.STEP(NDIV - 1 - i)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg      (div_cfg),
			.up_valid (up_v[i]),
			.up_data  (up_d[i]),
			.down_adv (down_adv[i]),
			.adv      (div_adv[i]),
			.valid    (div_valid[i]),
			.data     (div_data[i])
		);
	end

	// stall ripples back combinationally through each stage enable
	assign adv_s16 = !v_s16 || pixel.ready;
	assign adv_s3  = !v_s3 || div_adv[0];
	assign adv_s2  = !v_s2 || adv_s3;
	assign adv_s1  = !v_s1 || adv_s2;

	// ---------------------------------------------------------------------
	// Stage 16: pattern select and output register
	// ---------------------------------------------------------------------
	vtpg_pkg::vtpg_stage_t fin;
	logic [CH_W-1:0]       r_n, g_n, b_n, a_n;
	logic [CH_W-1:0]       lvl;
	logic [CH_W-1:0]       red_s16, green_s16, blue_s16, alpha_s16;
	logic                  outside_s16;

	always_comb begin
		fin = div_data[NDIV-1];
		lvl = '0;
		r_n = color_one_q[7:0];
		g_n = color_one_q[15:8];
		b_n = color_one_q[23:16];
		a_n = color_one_q[31:24];
		unique case (mode_q)
			vtpg_pkg::MODE_SOLID: ;
			vtpg_pkg::MODE_GRADIENT: begin
				// single-column frame keeps color one
				if (!d_zero) begin
					r_n = fin.gq[0];
					g_n = fin.gq[1];
					b_n = fin.gq[2];
					a_n = fin.gq[3];
				end
			end
			vtpg_pkg::MODE_CHECKER: begin
				lvl = (fin.xq ^ fin.yq) ? vtpg_pkg::GREY_HI : vtpg_pkg::GREY_LO;
				r_n = lvl;
				g_n = lvl;
				b_n = lvl;
				a_n = vtpg_pkg::ALPHA_OPAQUE;
			end
			vtpg_pkg::MODE_TEST: begin
				if (fin.bar_row) begin
					r_n = BAR_MASK[fin.bar][2] ? vtpg_pkg::BAR_LEVEL : '0;
					g_n = BAR_MASK[fin.bar][1] ? vtpg_pkg::BAR_LEVEL : '0;
					b_n = BAR_MASK[fin.bar][0] ? vtpg_pkg::BAR_LEVEL : '0;
				end else begin
					r_n = fin.rq;
					g_n = fin.rq;
					b_n = fin.rq;
				end
				if (fin.grid) begin
					r_n = vtpg_pkg::GRID_GREY;
					g_n = vtpg_pkg::GRID_GREY;
					b_n = vtpg_pkg::GRID_GREY;
				end
				a_n = vtpg_pkg::ALPHA_OPAQUE;
			end
			default: ;
		endcase
		// outside the frame: zero colour
		if (fin.outside) begin
			r_n = '0;
			g_n = '0;
			b_n = '0;
			a_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s16 <= 1'b0;
		end else if (adv_s16) begin
			v_s16 <= div_valid[NDIV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s16 && div_valid[NDIV-1]) begin
			red_s16     <= r_n;
			green_s16   <= g_n;
			blue_s16    <= b_n;
			alpha_s16   <= a_n;
			outside_s16 <= fin.outside;
		end
	end

	assign pixel.valid         = v_s16;
	assign pixel.red           = red_s16;
	assign pixel.green         = green_s16;
	assign pixel.blue          = blue_s16;
	assign pixel.alpha         = alpha_s16;
	assign pixel.outside_frame = outside_s16;

endmodule

`default_nettype wire

FILE: sv/vtpg_checker.sv
`default_nettype none

module vtpg_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [vtpg_pkg::ADDR_W-1:0]  paddr,
	input logic [vtpg_pkg::DATA_W-1:0]  pwdata,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [vtpg_pkg::CH_W-1:0]    red,
	input logic [vtpg_pkg::CH_W-1:0]    green,
	input logic [vtpg_pkg::CH_W-1:0]    blue,
	input logic [vtpg_pkg::CH_W-1:0]    alpha,
	input logic                         outside_frame
);

	vtpg_pkg::vtpg_mode_t mode_q;

	// track the pattern mode from the register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= vtpg_pkg::MODE_SOLID;
		end else if (psel && penable && pwrite &&
		             paddr[vtpg_pkg::ADDR_W-1:2] == vtpg_pkg::REG_MODE) begin
			mode_q <= vtpg_pkg::vtpg_mode_t'(pwdata[1:0]);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable({red, green, blue, alpha, outside_frame}))
		else $error("pixel word changed while stalled");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outside_frame |->
		red == '0 && green == '0 && blue == '0 && alpha == '0)
		else $error("outside pixel carries colour");

	a_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !outside_frame &&
		(mode_q == vtpg_pkg::MODE_CHECKER || mode_q == vtpg_pkg::MODE_TEST) |->
		alpha == vtpg_pkg::ALPHA_OPAQUE)
		else $error("checker or test pixel not opaque");

	a_checker_grey: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !outside_frame && mode_q == vtpg_pkg::MODE_CHECKER |->
		red == green && green == blue &&
		(red == vtpg_pkg::GREY_HI || red == vtpg_pkg::GREY_LO))
		else $error("checker pixel is not one of the two greys");

endmodule

bind video_test_pattern_generator vtpg_checker u_vtpg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.psel          (psel),
	.penable       (penable),
	.pwrite        (pwrite),
	.paddr         (paddr),
	.pwdata        (pwdata),
	.out_valid     (pixel.valid),
	.out_ready     (pixel.ready),
	.red           (pixel.red),
	.green         (pixel.green),
	.blue          (pixel.blue),
	.alpha         (pixel.alpha),
	.outside_frame (pixel.outside_frame)
);

`default_nettype wire

FILE: sim/video_test_pattern_generator_tb.sv
`timescale 1ns / 100ps

module video_test_pattern_generator_tb;

	localparam int unsigned PIX_W    = vtpg_pkg::PIX_W;
	localparam int unsigned DIM_W    = vtpg_pkg::DIM_W;
	localparam int unsigned CH_W     = vtpg_pkg::CH_W;
	localparam int unsigned ADDR_W   = vtpg_pkg::ADDR_W;
	localparam int unsigned DATA_W   = vtpg_pkg::DATA_W;
	localparam int unsigned NUM_CH   = vtpg_pkg::NUM_CH;
	localparam int unsigned NUM_BARS = vtpg_pkg::NUM_BARS;
	localparam int unsigned MAX_DIM  = vtpg_pkg::MAX_DIM;

	// delay from coordinate to result word through the top-level pipeline
	localparam int unsigned PIPE_LATENCY = 15;
	localparam int unsigned RUN_LIMIT    = 400000;
	localparam int unsigned MAX_WAIT     = 17;
	localparam int unsigned GRID_STEP    = 1 << vtpg_pkg::GRID_LOG2;
	localparam int unsigned RANDOM_PHASES = 14;
	localparam int unsigned PHASE_WORDS   = 105;

	// unused register slots past the checker size; writes there must change nothing
	localparam int unsigned REG_SPARE_LO = 6;
	localparam int unsigned REG_SPARE_HI = 7;

	// {red, green, blue} presence per bar, left to right
	localparam logic [0:NUM_BARS-1][2:0] BAR_RGB =
		{3'b111, 3'b110, 3'b011, 3'b010, 3'b101, 3'b100, 3'b001};

	typedef struct packed {
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
	} coord_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha;
		logic            outside;
	} pixel_word_t;

	typedef struct packed {
		coord_t      at;
		pixel_word_t rgba;
	} pixel_expect_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	vtpg_coord_if coord_bus ();
	vtpg_pixel_if pixel_bus ();

	video_test_pattern_generator i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.coord   (coord_bus),
		.pixel   (pixel_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the register file, at reset values until first written.
	vtpg_pkg::vtpg_mode_t cfg_mode      = vtpg_pkg::MODE_SOLID;
	logic [DIM_W-1:0]     cfg_width     = 13'd320;
	logic [DIM_W-1:0]     cfg_height    = 13'd240;
	logic [31:0]          cfg_color_one = 32'hFF00_0000;
	logic [31:0]          cfg_color_two = 32'hFFFF_FFFF;
	logic [DIM_W-1:0]     cfg_checker   = 13'd32;

	coord_t        pending_coords[$];
	pixel_expect_t expected_pixels[$];

	logic          sender_hold = 1'b0;
	logic          src_calm    = 1'b0;
	logic          snk_calm    = 1'b0;
	logic [4:0]    gap_left;
	logic [4:0]    stall_left;
	int unsigned   stall;
	int unsigned   mismatch_count = 0;
	int unsigned   cycle_count    = 0;
	coord_t        next_coord;
	pixel_expect_t want;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Hard stop in case the pipeline wedges.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic flag_pixel_mismatch(input string msg);
		mismatch_count++;
		$display("[%0d] pixel mismatch: %s", cycle_count, msg);
	endtask

	// Per-item wait for either side: calm stretches draw nothing, otherwise
	// roughly one word in three waits somewhere in the full range.
	function automatic int unsigned draw_wait(input logic calm);
		if (calm || $urandom_range(0, 2) != 0)
			return 0;
		return $urandom_range(0, MAX_WAIT);
	endfunction

	// Expected RGBA for one coordinate under the current register settings.
	function automatic pixel_word_t shade_pixel(input logic [PIX_W-1:0] px,
			input logic [PIX_W-1:0] py);
		int unsigned      x, y, w, h, d, sz, bar, c, a, b;
		logic [CH_W-1:0]  grey;
		logic [3:0][7:0]  blend;
		logic [2:0]       mask;
		pixel_word_t      p;
		x = px;
		y = py;
		w = (cfg_width > MAX_DIM) ? MAX_DIM : cfg_width;
		h = (cfg_height > MAX_DIM) ? MAX_DIM : cfg_height;
		p = '0;
		// zero-sized frames fall out here as well: every coordinate is outside
		if (x >= w || y >= h) begin
			p.outside = 1'b1;
			return p;
		end
		case (cfg_mode)
		vtpg_pkg::MODE_SOLID: begin
			{p.alpha, p.blue, p.green, p.red} = cfg_color_one;
		end
		vtpg_pkg::MODE_GRADIENT: begin
			d = w - 1;
			for (c = 0; c < NUM_CH; c++) begin
				a = cfg_color_one[8*c +: 8];
				b = cfg_color_two[8*c +: 8];
				// round half up: floor((2*blend + d) / (2*d)); one-wide frame holds color one
				blend[c] = (d == 0) ? CH_W'(a) :
					CH_W'((2 * (a * (d - x) + b * x) + d) / (2 * d));
			end
			{p.alpha, p.blue, p.green, p.red} = blend;
		end
		vtpg_pkg::MODE_CHECKER: begin
			sz = (cfg_checker == 0) ? 1 : cfg_checker;
			grey = (((x / sz) + (y / sz)) & 1) ? vtpg_pkg::GREY_HI : vtpg_pkg::GREY_LO;
			p.red   = grey;
			p.green = grey;
			p.blue  = grey;
			p.alpha = vtpg_pkg::ALPHA_OPAQUE;
		end
		default: begin
			p.alpha = vtpg_pkg::ALPHA_OPAQUE;
			if (y < (h * 2) / 3) begin
				bar = (x * 7) / w;
				if (bar > NUM_BARS - 1)
					bar = NUM_BARS - 1;
				mask = BAR_RGB[bar];
				p.red   = mask[2] ? vtpg_pkg::BAR_LEVEL : '0;
				p.green = mask[1] ? vtpg_pkg::BAR_LEVEL : '0;
				p.blue  = mask[0] ? vtpg_pkg::BAR_LEVEL : '0;
			end else begin
				grey = CH_W'((x * 255) / ((w > 1) ? w - 1 : 1));
				p.red   = grey;
				p.green = grey;
				p.blue  = grey;
			end
			if (x % GRID_STEP == 0 || y % GRID_STEP == 0) begin
				p.red   = vtpg_pkg::GRID_GREY;
				p.green = vtpg_pkg::GRID_GREY;
				p.blue  = vtpg_pkg::GRID_GREY;
			end
		end
		endcase
		return p;
	endfunction

	// Coordinate driver: hold the word until taken, then sit out the drawn gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_bus.valid   <= 1'b0;
			coord_bus.pixel_x <= '0;
			coord_bus.pixel_y <= '0;
			gap_left          <= '0;
		end else if (!coord_bus.valid || coord_bus.ready) begin
			if (coord_bus.valid)
				expected_pixels.push_back('{
					at:   '{x: coord_bus.pixel_x, y: coord_bus.pixel_y},
					rgba: shade_pixel(coord_bus.pixel_x, coord_bus.pixel_y)});
			if (gap_left != 0) begin
				coord_bus.valid <= 1'b0;
				gap_left        <= gap_left - 1'b1;
			end else if (pending_coords.size() != 0 && !sender_hold) begin
				next_coord = pending_coords.pop_front();
				coord_bus.valid   <= 1'b1;
				coord_bus.pixel_x <= next_coord.x;
				coord_bus.pixel_y <= next_coord.y;
				gap_left          <= 5'(draw_wait(src_calm));
			end else begin
				coord_bus.valid <= 1'b0;
			end
		end
	end

	// Pixel monitor: check each accepted word against the oldest expectation,
	// then drop ready for the drawn stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bus.ready <= 1'b0;
			stall_left      <= '0;
		end else begin
			stall = stall_left;
			if (pixel_bus.valid && pixel_bus.ready) begin
				if (expected_pixels.size() == 0) begin
					flag_pixel_mismatch("pixel word with no coordinate outstanding");
				end else begin
					want = expected_pixels.pop_front();
					if (pixel_bus.red !== want.rgba.red || pixel_bus.green !== want.rgba.green ||
							pixel_bus.blue !== want.rgba.blue ||
							pixel_bus.alpha !== want.rgba.alpha ||
							pixel_bus.outside_frame !== want.rgba.outside)
						flag_pixel_mismatch($sformatf(
							"(%0d,%0d) got %0d/%0d/%0d/%0d out %b, want %0d/%0d/%0d/%0d out %b",
							want.at.x, want.at.y, pixel_bus.red, pixel_bus.green,
							pixel_bus.blue, pixel_bus.alpha, pixel_bus.outside_frame,
							want.rgba.red, want.rgba.green, want.rgba.blue,
							want.rgba.alpha, want.rgba.outside));
				end
				stall = draw_wait(snk_calm);
			end
			if (stall != 0) begin
				pixel_bus.ready <= 1'b0;
				stall_left      <= 5'(stall - 1);
			end else begin
				pixel_bus.ready <= 1'b1;
				stall_left      <= '0;
			end
		end
	end

	// APB write: setup then access; junk above the register width must be dropped.
	task automatic write_reg(input int unsigned idx, input logic [31:0] value,
			input int unsigned width);
		logic [31:0] data;
		data = ($urandom << width) | value;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx * 4);
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
		vtpg_pkg::REG_MODE:         cfg_mode      = vtpg_pkg::vtpg_mode_t'(data[1:0]);
		vtpg_pkg::REG_FRAME_WIDTH:  cfg_width     = data[DIM_W-1:0];
		vtpg_pkg::REG_FRAME_HEIGHT: cfg_height    = data[DIM_W-1:0];
		vtpg_pkg::REG_COLOR_ONE:    cfg_color_one = data;
		vtpg_pkg::REG_COLOR_TWO:    cfg_color_two = data;
		vtpg_pkg::REG_CHECKER_SIZE: cfg_checker   = data[DIM_W-1:0];
		default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Advance until every queued coordinate has been sent and answered.
	task automatic wait_drained();
		while (pending_coords.size() != 0 || coord_bus.valid || expected_pixels.size() != 0)
			@(negedge clk);
	endtask

	task automatic apply_cfg(input vtpg_pkg::vtpg_mode_t mode, input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h, input logic [31:0] c1, input logic [31:0] c2,
			input logic [DIM_W-1:0] sz);
		wait_drained();
		write_reg(vtpg_pkg::REG_MODE, 32'(mode), 2);
		write_reg(vtpg_pkg::REG_FRAME_WIDTH, 32'(w), DIM_W);
		write_reg(vtpg_pkg::REG_FRAME_HEIGHT, 32'(h), DIM_W);
		write_reg(vtpg_pkg::REG_COLOR_ONE, c1, 32);
		write_reg(vtpg_pkg::REG_COLOR_TWO, c2, 32);
		write_reg(vtpg_pkg::REG_CHECKER_SIZE, 32'(sz), DIM_W);
		write_reg(REG_SPARE_LO, $urandom, 32);
		write_reg(REG_SPARE_HI, $urandom, 32);
		@(negedge clk);
	endtask

	task automatic queue_coord(input int unsigned x, input int unsigned y);
		pending_coords.push_back('{x: x[PIX_W-1:0], y: y[PIX_W-1:0]});
	endtask

	// One axis of a random coordinate: mostly inside the frame, with the edges,
	// grid lines, the bar/ramp boundary and the full 12-bit range mixed in.
	function automatic logic [PIX_W-1:0] pick_axis(input int unsigned span,
			input int unsigned mark);
		int unsigned v;
		case ($urandom_range(0, 11))
		0: v = $urandom_range(0, 4095);
		1: v = (span > 4095) ? 4095 : span;
		2: v = span - 1;
		3: v = $urandom_range(0, 127) * GRID_STEP;
		4: v = mark - $urandom_range(0, 1);
		default: v = (span == 0) ? $urandom_range(0, 4095) : $urandom_range(0, span - 1);
		endcase
		return v[PIX_W-1:0];
	endfunction

	task automatic queue_random(input int unsigned count);
		int unsigned w, h;
		w = (cfg_width > MAX_DIM) ? MAX_DIM : cfg_width;
		h = (cfg_height > MAX_DIM) ? MAX_DIM : cfg_height;
		repeat (count)
			pending_coords.push_back('{x: pick_axis(w, w), y: pick_axis(h, (h * 2) / 3)});
	endtask

	// Frame or square size: half the time full range, otherwise small or past the clamp.
	function automatic logic [DIM_W-1:0] rand_dim();
		case ($urandom_range(0, 7))
		0:       return DIM_W'($urandom_range(4097, 8191));
		1:       return DIM_W'($urandom_range(1, 8));
		2, 3:    return DIM_W'($urandom_range(1, 200));
		default: return DIM_W'($urandom_range(1, 4096));
		endcase
	endfunction

	initial begin
		int unsigned ph;
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: solid opaque black on a 320x240 frame, both edges.
		queue_coord(0, 0);
		queue_coord(319, 239);
		queue_coord(320, 0);
		queue_coord(0, 240);
		queue_coord(4095, 4095);

		// Gradient between opposite full-scale colors: ends, middle, first step.
		apply_cfg(vtpg_pkg::MODE_GRADIENT, 320, 240, 32'hFF00_FF00, 32'h00FF_00FF, 32);
		queue_coord(0, 7);
		queue_coord(319, 7);
		queue_coord(160, 0);
		queue_coord(1, 239);

		// Zero checker size acts as single-pixel squares.
		apply_cfg(vtpg_pkg::MODE_CHECKER, 64, 64, 32'h0, 32'h0, 0);
		queue_coord(0, 0);
		queue_coord(1, 0);
		queue_coord(1, 1);
		queue_coord(63, 62);

		// Bars, ramp and grid: grid column, first and last bar, ramp end, grid column in the bars.
		apply_cfg(vtpg_pkg::MODE_TEST, 640, 480, 32'h0, 32'h0, 32);
		queue_coord(0, 5);
		queue_coord(33, 33);
		queue_coord(639, 1);
		queue_coord(300, 479);
		queue_coord(320, 100);

		// One-pixel-wide gradient holds color one; oversize height clamps to 4096.
		apply_cfg(vtpg_pkg::MODE_GRADIENT, 1, 8191, 32'h1234_5678, 32'hFFFF_FFFF, 32);
		queue_coord(0, 0);
		queue_coord(0, 4095);
		queue_coord(1, 0);

		// Zero width puts everything outside.
		apply_cfg(vtpg_pkg::MODE_SOLID, 0, 10, 32'hFFFF_FFFF, 32'h0, 32);
		queue_coord(0, 0);

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
			0: apply_cfg(vtpg_pkg::MODE_TEST, 4096, 4096, $urandom, $urandom, 32);
			1: apply_cfg(vtpg_pkg::MODE_GRADIENT, 8191, 4096, 32'h0, 32'hFFFF_FFFF, 1);
			2: apply_cfg(vtpg_pkg::MODE_CHECKER, 4096, 8191, $urandom, $urandom, 8191);
			3: apply_cfg(vtpg_pkg::MODE_CHECKER, DIM_W'($urandom_range(1, 100)),
					DIM_W'($urandom_range(1, 100)), $urandom, $urandom, 1);
			4: apply_cfg(vtpg_pkg::MODE_GRADIENT, 2, rand_dim(), 32'hFFFF_FFFF, 32'h0,
					rand_dim());
			5: apply_cfg(vtpg_pkg::MODE_TEST, DIM_W'($urandom_range(1, 9)), 3, $urandom,
					$urandom, 32);
			6: apply_cfg(vtpg_pkg::MODE_SOLID, 4096, 4096, $urandom, $urandom, rand_dim());
			default: apply_cfg(vtpg_pkg::vtpg_mode_t'($urandom_range(0, 3)), rand_dim(),
					rand_dim(), $urandom, $urandom, ($urandom_range(0, 3) == 0) ? rand_dim() :
					DIM_W'($urandom_range(1, 64)));
			endcase
			src_calm = ($urandom_range(0, 3) == 0);
			snk_calm = ($urandom_range(0, 3) == 0);
			queue_random(PHASE_WORDS);
			// Hold the sender mid-phase until the pipeline has emptied out.
			if (ph == 3 || ph == 9) begin
				while (pending_coords.size() > PHASE_WORDS / 2)
					@(negedge clk);
				sender_hold = 1'b1;
				while (coord_bus.valid || expected_pixels.size() != 0)
					@(negedge clk);
				sender_hold = 1'b0;
			end
		end

		wait_drained();
		repeat (2 * PIPE_LATENCY) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
sv/vtpg_pkg.sv
sv/vtpg_ifs.sv
sv/vtpg_div_stage.sv
sv/video_test_pattern_generator.sv
sv/vtpg_checker.sv
sim/video_test_pattern_generator_tb.sv
